// ----- hw/rtl/tlr_pkg.sv -----
// shared types, constants and controller codes for the triplet loss block
// no dependencies; used by the interfaces and every module
package tlr_pkg;

	localparam int SUM_W        = 48;
	localparam int ELEM_W       = 16;
	localparam int SQ_W         = 32;
	localparam int MARGIN_W     = 32;
	localparam int WEIGHT_W     = 16;
	localparam int CFG_IDX_W    = 8;
	localparam int CFG_DATA_W   = 32;
	localparam int MAX_BATCH_DEF = 256;

	localparam logic [SUM_W-1:0]    SUM_MAX      = {SUM_W{1'b1}};
	localparam logic [MARGIN_W-1:0] MARGIN_RESET = 32'd3355443;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd410;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_MARGIN     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REG_WEIGHT = 8'd1;

	typedef struct packed {
		logic signed [ELEM_W-1:0] anchor_elem;
		logic signed [ELEM_W-1:0] positive_elem;
		logic signed [ELEM_W-1:0] negative_elem;
		logic signed [ELEM_W-1:0] anchor_ref_elem;
		logic signed [ELEM_W-1:0] positive_ref_elem;
		logic signed [ELEM_W-1:0] negative_ref_elem;
		logic                     vector_end;
		logic                     batch_end;
	} elem_t;

	typedef struct packed {
		logic [SUM_W-1:0] sample_loss;
		logic             hinge_active;
		logic [SUM_W-1:0] batch_mean;
		logic             batch_done;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_HINGE,
		ST_MULHI,
		ST_REGSAT,
		ST_LOSS,
		ST_BATCH,
		ST_DIVGO,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic take;
		logic hinge;
		logic mul_hi;
		logic reg_sat;
		logic loss;
		logic batch;
		logic div_start;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic closes;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

// ----- hw/rtl/tlr_if.sv -----
// valid/ready channel interfaces for element requests, results and register writes
// depends on tlr_pkg for the payload types
interface tlr_elem_if;
	import tlr_pkg::*;
	logic  valid;
	logic  ready;
	elem_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tlr_res_if;
	import tlr_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tlr_cfg_if;
	import tlr_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  idx;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output idx, output data, input ready);
	modport sink (input valid, input idx, input data, output ready);
endinterface

// ----- hw/rtl/tlr_div.sv -----
// restoring divider, one quotient bit per cycle, for the batch mean
// depends on tlr_pkg for the sum width
module tlr_div #(
	parameter int DIV_W = 9
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [tlr_pkg::SUM_W-1:0] dividend,
	input  logic [DIV_W-1:0]         divisor,
	output logic                     done,
	output logic [tlr_pkg::SUM_W-1:0] quotient
);
	import tlr_pkg::*;

	localparam int CNT_W = $clog2(SUM_W + 1);

	logic             running_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] quo_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] div_q;
	logic [DIV_W:0]   rem_shift;
	logic [DIV_W:0]   rem_sub;
	logic             fits;

	assign rem_shift = {rem_q, quo_q[SUM_W-1]};
	assign fits      = rem_shift >= {1'b0, div_q};
	assign rem_sub   = rem_shift - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				running_q <= 1'b1;
				cnt_q     <= CNT_W'(SUM_W);
			end else if (running_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					running_q <= 1'b0;
					done_q    <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (running_q) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= fits ? rem_sub[DIV_W-1:0] : rem_shift[DIV_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- hw/rtl/tlr_dp.sv -----
// datapath: squared differences, distance sums, loss, batch sum and result register
// depends on tlr_pkg and instantiates tlr_div
module tlr_dp #(
	parameter int MAX_BATCH = tlr_pkg::MAX_BATCH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tlr_pkg::cmd_t                cmd,
	output tlr_pkg::status_t             status,
	input  tlr_pkg::elem_t               elem_data,
	input  logic                         cfg_we,
	input  logic [tlr_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [tlr_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                         res_valid,
	input  logic                         res_ready,
	output tlr_pkg::res_t                res_data
);
	import tlr_pkg::*;

	localparam int CNT_W = $clog2(MAX_BATCH + 1);
	localparam int HALF  = SUM_W / 2;
	localparam int PROD_W = WEIGHT_W + HALF;

	function automatic logic [SQ_W-1:0] sq_diff(
		input logic signed [ELEM_W-1:0] x,
		input logic signed [ELEM_W-1:0] y
	);
		logic [ELEM_W:0]   d;
		logic [ELEM_W:0]   m;
		logic [ELEM_W-1:0] mm;
		d  = {x[ELEM_W-1], x} - {y[ELEM_W-1], y};
		m  = d[ELEM_W] ? (~d + (ELEM_W+1)'(1)) : d;
		mm = m[ELEM_W-1:0];
		return SQ_W'(mm) * SQ_W'(mm);
	endfunction

	logic [MARGIN_W-1:0] margin_q;
	logic [WEIGHT_W-1:0] weight_q;

	logic            valid_s1;
	logic [SQ_W-1:0] sq_pos_s1;
	logic [SQ_W-1:0] sq_neg_s1;
	logic [SQ_W-1:0] sq_ra_s1;
	logic [SQ_W-1:0] sq_rp_s1;
	logic [SQ_W-1:0] sq_rn_s1;

	logic [SUM_W-1:0] pos_acc_q;
	logic [SUM_W-1:0] neg_acc_q;
	logic [SUM_W-1:0] ref_acc_q;
	logic [SUM_W-1:0] batch_sum_q;
	logic [CNT_W-1:0] count_q;
	logic             close_q;

	logic [SUM_W:0]   hinge_q;
	logic             active_q;
	logic [PROD_W-1:0] prod_lo_q;
	logic [PROD_W-1:0] prod_hi_q;
	logic [SUM_W-1:0] reg_sat_q;
	logic [SUM_W-1:0] loss_q;

	logic             res_valid_q;
	res_t             res_q;

	logic [SUM_W:0]   pos_sum;
	logic [SUM_W:0]   neg_sum;
	logic [SUM_W+1:0] ref_sum;
	logic [SUM_W+1:0] hinge_diff;
	logic [63:0]      prod_full;
	logic [SUM_W+1:0] loss_sum;
	logic [SUM_W:0]   batch_sum;
	logic             div_done;
	logic [SUM_W-1:0] quotient;

	assign pos_sum = {1'b0, pos_acc_q} + (SUM_W+1)'(sq_pos_s1);
	assign neg_sum = {1'b0, neg_acc_q} + (SUM_W+1)'(sq_neg_s1);
	// three reference terms at once: sticky saturation makes this equal to three steps
	assign ref_sum = {2'b0, ref_acc_q} + (SUM_W+2)'(sq_ra_s1) + (SUM_W+2)'(sq_rp_s1)
		+ (SUM_W+2)'(sq_rn_s1);
	assign hinge_diff = (SUM_W+2)'(margin_q) + {2'b0, pos_acc_q} - {2'b0, neg_acc_q};
	assign prod_full  = {prod_hi_q, {HALF{1'b0}}} + 64'(prod_lo_q);
	assign loss_sum   = {1'b0, hinge_q} + (SUM_W+2)'(reg_sat_q);
	assign batch_sum  = {1'b0, batch_sum_q} + {1'b0, loss_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= MARGIN_RESET;
			weight_q <= WEIGHT_RESET;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_MARGIN) begin
				margin_q <= cfg_data[MARGIN_W-1:0];
			end else if (cfg_idx == CFG_REG_WEIGHT) begin
				weight_q <= cfg_data[WEIGHT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.take;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			sq_pos_s1 <= sq_diff(elem_data.anchor_elem, elem_data.positive_elem);
			sq_neg_s1 <= sq_diff(elem_data.anchor_elem, elem_data.negative_elem);
			sq_ra_s1  <= sq_diff(elem_data.anchor_elem, elem_data.anchor_ref_elem);
			sq_rp_s1  <= sq_diff(elem_data.positive_elem, elem_data.positive_ref_elem);
			sq_rn_s1  <= sq_diff(elem_data.negative_elem, elem_data.negative_ref_elem);
			if (elem_data.vector_end) begin
				close_q <= elem_data.batch_end;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_acc_q   <= '0;
			neg_acc_q   <= '0;
			ref_acc_q   <= '0;
			batch_sum_q <= '0;
			count_q     <= '0;
		end else begin
			if (cmd.loss) begin
				pos_acc_q <= '0;
				neg_acc_q <= '0;
				ref_acc_q <= '0;
			end else if (valid_s1) begin
				pos_acc_q <= pos_sum[SUM_W] ? SUM_MAX : pos_sum[SUM_W-1:0];
				neg_acc_q <= neg_sum[SUM_W] ? SUM_MAX : neg_sum[SUM_W-1:0];
				ref_acc_q <= (|ref_sum[SUM_W+1:SUM_W]) ? SUM_MAX : ref_sum[SUM_W-1:0];
			end
			if (cmd.div_start) begin
				batch_sum_q <= '0;
				count_q     <= '0;
			end else if (cmd.batch) begin
				batch_sum_q <= batch_sum[SUM_W] ? SUM_MAX : batch_sum[SUM_W-1:0];
				if (count_q < CNT_W'(MAX_BATCH)) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hinge) begin
			active_q  <= !hinge_diff[SUM_W+1] && (hinge_diff != '0);
			hinge_q   <= (!hinge_diff[SUM_W+1] && (hinge_diff != '0))
				? hinge_diff[SUM_W:0] : '0;
			prod_lo_q <= PROD_W'(weight_q) * PROD_W'(ref_acc_q[HALF-1:0]);
		end
		if (cmd.mul_hi) begin
			prod_hi_q <= PROD_W'(weight_q) * PROD_W'(ref_acc_q[SUM_W-1:HALF]);
		end
		if (cmd.reg_sat) begin
			// drop 12 fraction bits of the Q4.12 weight, then clamp
			reg_sat_q <= (|prod_full[63:SUM_W+12]) ? SUM_MAX : prod_full[SUM_W+11:12];
		end
		if (cmd.loss) begin
			loss_q <= (|loss_sum[SUM_W+1:SUM_W]) ? SUM_MAX : loss_sum[SUM_W-1:0];
		end
	end

	tlr_div #(
		.DIV_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (batch_sum_q),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_q.sample_loss  <= loss_q;
			res_q.hinge_active <= active_q;
			res_q.batch_mean   <= close_q ? quotient : '0;
			res_q.batch_done   <= close_q;
		end
	end

	assign res_valid       = res_valid_q;
	assign res_data        = res_q;
	assign status.closes   = close_q;
	assign status.div_done = div_done;
	assign status.out_free = !res_valid_q || res_ready;

endmodule

// ----- hw/rtl/tlr_ctrl.sv -----
// controller: streams elements, then sequences the end-of-sample steps
// depends on tlr_pkg for state, command and status types
module tlr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             elem_valid,
	input  logic             elem_vec_end,
	output logic             elem_ready,
	input  tlr_pkg::status_t status,
	output tlr_pkg::cmd_t    cmd
);
	import tlr_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		elem_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				elem_ready = 1'b1;
				cmd.take   = elem_valid;
				if (elem_valid && elem_vec_end) begin
					state_d = ST_DRAIN;
				end
			end
			// last element's squares land in the sums
			ST_DRAIN: begin
				state_d = ST_HINGE;
			end
			ST_HINGE: begin
				cmd.hinge = 1'b1;
				state_d   = ST_MULHI;
			end
			ST_MULHI: begin
				cmd.mul_hi = 1'b1;
				state_d    = ST_REGSAT;
			end
			ST_REGSAT: begin
				cmd.reg_sat = 1'b1;
				state_d     = ST_LOSS;
			end
			ST_LOSS: begin
				cmd.loss = 1'b1;
				state_d  = ST_BATCH;
			end
			ST_BATCH: begin
				cmd.batch = 1'b1;
				state_d   = status.closes ? ST_DIVGO : ST_OUT;
			end
			ST_DIVGO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/triplet_loss_with_reg.sv -----
// triplet margin loss with reference penalty: one element request per cycle while a
// sample is open; after the closing element ready stays low until its result is loaded,
// which waits on the 48-step serial divider when it also closes the batch, and waits
// for as long as the result register is still full.
// the result register lets the next sample stream in while a result waits.
// arst_n clears all sums, counts and handshakes and loads the register reset values.
module triplet_loss_with_reg #(
	parameter int MAX_BATCH = tlr_pkg::MAX_BATCH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	tlr_elem_if.sink  elem,
	tlr_res_if.source result,
	tlr_cfg_if.sink   cfg
);
	import tlr_pkg::*;

	cmd_t    cmd;
	status_t status;
	logic    elem_ready;

	assign cfg.ready  = 1'b1;
	assign elem.ready = elem_ready;

	tlr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.elem_valid   (elem.valid),
		.elem_vec_end (elem.data.vector_end),
		.elem_ready   (elem_ready),
		.status       (status),
		.cmd          (cmd)
	);

	tlr_dp #(
		.MAX_BATCH (MAX_BATCH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.elem_data (elem.data),
		.cfg_we    (cfg.valid),
		.cfg_idx   (cfg.idx),
		.cfg_data  (cfg.data),
		.res_valid (result.valid),
		.res_ready (result.ready),
		.res_data  (result.data)
	);

endmodule
